// ===== src/sipd_pkg.sv =====
// ----------------------------------------------------------------------------
// sipd_pkg
// Shared types and constants of the sync/ID packet deframer.
// ----------------------------------------------------------------------------
package sipd_pkg;

	localparam int PAYLOAD_BYTES = 24;
	localparam int WORD_COUNT    = 6;
	localparam int WORD_W        = 32;
	localparam int COUNT_W       = 5;
	localparam int CFG_INDEX_W   = 2;

	localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(PAYLOAD_BYTES - 1);

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h1A;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h1B;
	localparam logic [7:0] MESSAGE_ID_RST  = 8'h2C;

	localparam int MID_DEPTH_DFLT = 2;
	localparam int OUT_DEPTH_DFLT = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SYNC_FIRST  = 2'd0,
		CFG_SYNC_SECOND = 2'd1,
		CFG_MESSAGE_ID  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_HUNT    = 2'd0,
		ST_SYNC2   = 2'd1,
		ST_ID      = 2'd2,
		ST_PAYLOAD = 2'd3
	} frame_state_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_STORE = 2'd1,
		OP_LAST  = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic                     new_packet;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] pos_z;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] vel_z;
	} result_t;

endpackage

// ===== src/sipd_fifo.sv =====
// ----------------------------------------------------------------------------
// sipd_fifo
// Small register queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
module sipd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_ok, pop_ok})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				2'b00: count_q <= count_q;
				2'b11: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Queue holds more entries than its depth.");

endmodule

// ===== src/sipd_front.sv =====
// ----------------------------------------------------------------------------
// sipd_front
// Frame hunter: tracks sync bytes, ID and payload position, holds the
// configuration registers and turns each received byte into a command.
// ----------------------------------------------------------------------------
module sipd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [7:0]                          rx_byte,
	input  logic                                cfg_valid,
	input  logic [sipd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data,
	output sipd_pkg::cmd_t                      cmd
);

	logic [7:0]                       sync_first_q;
	logic [7:0]                       sync_second_q;
	logic [7:0]                       message_id_q;
	sipd_pkg::frame_state_t           state_q;
	sipd_pkg::frame_state_t           state_d;
	logic [sipd_pkg::COUNT_W-1:0]     count_q;
	logic [sipd_pkg::COUNT_W-1:0]     count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= sipd_pkg::SYNC_FIRST_RST;
			sync_second_q <= sipd_pkg::SYNC_SECOND_RST;
			message_id_q  <= sipd_pkg::MESSAGE_ID_RST;
		end else if (cfg_valid) begin
			unique case (sipd_pkg::cfg_idx_t'(cfg_index))
				sipd_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				sipd_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				sipd_pkg::CFG_MESSAGE_ID:  message_id_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		if (accept) begin
			unique case (state_q)
				sipd_pkg::ST_HUNT: begin
					if (rx_byte == sync_first_q) begin
						state_d = sipd_pkg::ST_SYNC2;
					end
					count_d = '0;
				end
				sipd_pkg::ST_SYNC2: begin
					state_d = (rx_byte == sync_second_q) ? sipd_pkg::ST_ID : sipd_pkg::ST_HUNT;
					count_d = '0;
				end
				sipd_pkg::ST_ID: begin
					state_d = (rx_byte == message_id_q) ? sipd_pkg::ST_PAYLOAD
					                                    : sipd_pkg::ST_HUNT;
					count_d = '0;
				end
				sipd_pkg::ST_PAYLOAD: begin
					priority if (count_q < sipd_pkg::LAST_INDEX) begin
						count_d = count_q + 1'b1;
					end else begin
						state_d = sipd_pkg::ST_HUNT;
						count_d = '0;
					end
				end
			endcase
		end
	end

	always_comb begin
		cmd.data = rx_byte;
		cmd.op   = sipd_pkg::OP_NONE;
		if (state_q == sipd_pkg::ST_PAYLOAD) begin
			priority if (count_q == sipd_pkg::LAST_INDEX) begin
				cmd.op = sipd_pkg::OP_LAST;
			end else if (count_q < sipd_pkg::LAST_INDEX) begin
				cmd.op = sipd_pkg::OP_STORE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sipd_pkg::ST_HUNT;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sipd_pkg::ST_PAYLOAD) |-> (count_q == '0))
		else $error("Payload count is nonzero outside the payload state.");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.op == sipd_pkg::OP_LAST) |=>
			(state_q == sipd_pkg::ST_HUNT && count_q == '0))
		else $error("Frame did not return to the hunt after its last byte.");

endmodule

// ===== src/sipd_back.sv =====
// ----------------------------------------------------------------------------
// sipd_back
// Payload collector: shifts in payload bytes, assembles the six
// little-endian words on the last byte and issues one result per command.
// ----------------------------------------------------------------------------
module sipd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sipd_pkg::cmd_t    cmd,
	input  logic              mid_empty,
	output logic              mid_pop,
	input  logic              out_full,
	output logic              out_push,
	output sipd_pkg::result_t res
);

	localparam int SREG_N = sipd_pkg::PAYLOAD_BYTES - 1;

	logic [7:0]                                          sreg_q [0:SREG_N-1];
	logic [7:0]                                          bytes  [0:sipd_pkg::PAYLOAD_BYTES-1];
	logic [sipd_pkg::WORD_COUNT-1:0][sipd_pkg::WORD_W-1:0] latest_q;
	logic [sipd_pkg::WORD_COUNT-1:0][sipd_pkg::WORD_W-1:0] assembled;
	logic [sipd_pkg::WORD_COUNT-1:0][sipd_pkg::WORD_W-1:0] vals;
	logic                                                is_last;

	assign mid_pop  = !mid_empty && !out_full;
	assign out_push = mid_pop;
	assign is_last  = (cmd.op == sipd_pkg::OP_LAST);

	always_comb begin
		for (int i = 0; i < SREG_N; i++) begin
			bytes[i] = sreg_q[i];
		end
		bytes[SREG_N] = cmd.data;
		for (int k = 0; k < sipd_pkg::WORD_COUNT; k++) begin
			assembled[k] = {bytes[4*k+3], bytes[4*k+2], bytes[4*k+1], bytes[4*k]};
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop && cmd.op == sipd_pkg::OP_STORE) begin
			for (int i = 0; i < SREG_N - 1; i++) begin
				sreg_q[i] <= sreg_q[i+1];
			end
			sreg_q[SREG_N-1] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
		end else if (mid_pop && is_last) begin
			latest_q <= assembled;
		end
	end

	always_comb begin
		vals           = is_last ? assembled : latest_q;
		res.new_packet = is_last;
		res.pos_x      = $signed(vals[0]);
		res.pos_y      = $signed(vals[1]);
		res.pos_z      = $signed(vals[2]);
		res.vel_x      = $signed(vals[3]);
		res.vel_y      = $signed(vals[4]);
		res.vel_z      = $signed(vals[5]);
	end

	a_hold_values: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_pop && !is_last) |=> $stable(latest_q))
		else $error("Latest values changed without a completed packet.");

	a_load_values: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_pop && is_last) |=> (latest_q == $past(assembled)))
		else $error("Latest values do not match the assembled packet.");

endmodule

// ===== src/sync_id_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_id_packet_deframer_unit
// Finds frames of two sync bytes and an ID byte in a byte stream, collects
// the 24-byte payload and reports six signed fixed-point words per packet.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          rx_byte
// result    out        pop / empty          new_packet, pos_x..vel_z
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while full is low; every byte gives one result.
// The frame hunter writes the command for each accepted byte into the middle
// queue, and the payload collector moves it into the result queue once that
// queue has room; the result then shows at the outputs.
// Reset loads the default sync and ID values, clears both queues and sets
// the reported values to zero.
// The middle queue decouples the hunter from the collector; full rises
// only once the result and then the middle queue fill (MID_DEPTH above one).
// ----------------------------------------------------------------------------
module sync_id_packet_deframer_unit #(
	parameter int MID_DEPTH = sipd_pkg::MID_DEPTH_DFLT,
	parameter int OUT_DEPTH = sipd_pkg::OUT_DEPTH_DFLT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [7:0]                            rx_byte,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  new_packet,
	output logic signed [sipd_pkg::WORD_W-1:0]    pos_x,
	output logic signed [sipd_pkg::WORD_W-1:0]    pos_y,
	output logic signed [sipd_pkg::WORD_W-1:0]    pos_z,
	output logic signed [sipd_pkg::WORD_W-1:0]    vel_x,
	output logic signed [sipd_pkg::WORD_W-1:0]    vel_y,
	output logic signed [sipd_pkg::WORD_W-1:0]    vel_z,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sipd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [7:0]                            cfg_data
);

	logic              accept;
	sipd_pkg::cmd_t    front_cmd;
	sipd_pkg::cmd_t    mid_cmd;
	logic              mid_empty;
	logic              mid_pop;
	logic              out_full;
	logic              out_push;
	sipd_pkg::result_t back_res;
	sipd_pkg::result_t out_res;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	sipd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (front_cmd)
	);

	sipd_fifo #(
		.WIDTH ($bits(sipd_pkg::cmd_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_cmd),
		.empty  (mid_empty)
	);

	sipd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mid_cmd),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.res       (back_res)
	);

	sipd_fifo #(
		.WIDTH ($bits(sipd_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign new_packet = out_res.new_packet;
	assign pos_x      = out_res.pos_x;
	assign pos_y      = out_res.pos_y;
	assign pos_z      = out_res.pos_z;
	assign vel_x      = out_res.vel_x;
	assign vel_y      = out_res.vel_y;
	assign vel_z      = out_res.vel_z;

endmodule

// ===== dv/tb_sync_id_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sync_id_packet_deframer_unit
// Self-checking bench for the sync/ID packet deframer. A byte-level frame
// tracker predicts the reported words for every accepted byte. Directed
// frames come first, then randomized streams under several sync and ID
// settings. Both queue sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sync_id_packet_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sipd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_BYTES  = 90;
	localparam int SETTLE_TICKS = 8;

	class packet_tracker;
		logic [7:0]                         first_sync;
		logic [7:0]                         second_sync;
		logic [7:0]                         frame_id;
		sipd_pkg::frame_state_t             hunt_state;
		int unsigned                        stored;
		logic [7:0]                         frame_bytes[sipd_pkg::PAYLOAD_BYTES];
		logic signed [sipd_pkg::WORD_W-1:0] held_words[sipd_pkg::WORD_COUNT];
		sipd_pkg::result_t                  expected_readouts[$];
		int unsigned                        failures;
		int unsigned                        checked;
		int unsigned                        packets;

		function new();
			first_sync  = sipd_pkg::SYNC_FIRST_RST;
			second_sync = sipd_pkg::SYNC_SECOND_RST;
			frame_id    = sipd_pkg::MESSAGE_ID_RST;
			hunt_state  = sipd_pkg::ST_HUNT;
			stored      = 0;
			foreach (held_words[k]) held_words[k] = '0;
			failures = 0;
			checked  = 0;
			packets  = 0;
		endfunction

		function void write_reg(logic [sipd_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
			case (idx)
				sipd_pkg::CFG_SYNC_FIRST: begin
					first_sync = val;
				end
				sipd_pkg::CFG_SYNC_SECOND: begin
					second_sync = val;
				end
				sipd_pkg::CFG_MESSAGE_ID: begin
					frame_id = val;
				end
				default: begin
				end
			endcase
		endfunction

		function void absorb_byte(logic [7:0] b);
			sipd_pkg::result_t r;
			r.new_packet = 1'b0;
			case (hunt_state)
				sipd_pkg::ST_HUNT: begin
					if (b == first_sync) hunt_state = sipd_pkg::ST_SYNC2;
					stored = 0;
				end
				sipd_pkg::ST_SYNC2: begin
					hunt_state = (b == second_sync) ? sipd_pkg::ST_ID : sipd_pkg::ST_HUNT;
					stored = 0;
				end
				sipd_pkg::ST_ID: begin
					hunt_state = (b == frame_id) ? sipd_pkg::ST_PAYLOAD : sipd_pkg::ST_HUNT;
					stored = 0;
				end
				default: begin
					frame_bytes[stored] = b;
					stored++;
					if (stored == sipd_pkg::PAYLOAD_BYTES) begin
						for (int k = 0; k < sipd_pkg::WORD_COUNT; k++)
							held_words[k] = {frame_bytes[4*k+3], frame_bytes[4*k+2],
								frame_bytes[4*k+1], frame_bytes[4*k]};
						r.new_packet = 1'b1;
						packets++;
						stored = 0;
						hunt_state = sipd_pkg::ST_HUNT;
					end
				end
			endcase
			r.pos_x = held_words[0];
			r.pos_y = held_words[1];
			r.pos_z = held_words[2];
			r.vel_x = held_words[3];
			r.vel_y = held_words[4];
			r.vel_z = held_words[5];
			expected_readouts.push_back(r);
		endfunction

		function void check_result(sipd_pkg::result_t got);
			sipd_pkg::result_t want;
			if (expected_readouts.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with no request pending, new_packet=%0b pos_x=%0d",
						$time, got.new_packet, got.pos_x);
				return;
			end
			want = expected_readouts.pop_front();
			checked++;
			if (got.new_packet !== want.new_packet || got.pos_x !== want.pos_x ||
					got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
					got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
					got.vel_z !== want.vel_z) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: mismatch, expected new_packet=%0b pos=%0d,%0d,%0d vel=%0d,%0d,%0d",
						$time, want.new_packet, want.pos_x, want.pos_y, want.pos_z,
						want.vel_x, want.vel_y, want.vel_z);
					$display("%0t: mismatch, actual   new_packet=%0b pos=%0d,%0d,%0d vel=%0d,%0d,%0d",
						$time, got.new_packet, got.pos_x, got.pos_y, got.pos_z,
						got.vel_x, got.vel_y, got.vel_z);
				end
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n    = 1'b0;
	logic                                push      = 1'b0;
	logic                                full;
	logic [7:0]                          rx_byte   = 8'h00;
	logic                                empty;
	logic                                pop       = 1'b0;
	logic                                new_packet;
	logic signed [sipd_pkg::WORD_W-1:0]  pos_x;
	logic signed [sipd_pkg::WORD_W-1:0]  pos_y;
	logic signed [sipd_pkg::WORD_W-1:0]  pos_z;
	logic signed [sipd_pkg::WORD_W-1:0]  vel_x;
	logic signed [sipd_pkg::WORD_W-1:0]  vel_y;
	logic signed [sipd_pkg::WORD_W-1:0]  vel_z;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [sipd_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [7:0]                          cfg_data  = 8'h00;

	packet_tracker sb = new();

	logic [sipd_pkg::WORD_W-1:0] frame_words[sipd_pkg::WORD_COUNT];
	int unsigned       burst_left  = 5;
	int unsigned       phase_items = 0;
	int unsigned       sent_total  = 0;
	int unsigned       cfg_writes  = 0;
	int unsigned       settings    = 1;
	int unsigned       quiet_cycles = 0;
	int unsigned       pop_mode    = 0;
	int unsigned       pop_left    = 0;

	sync_id_packet_deframer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.new_packet (new_packet),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		sipd_pkg::result_t got;
		if (arst_n && pop && !empty) begin
			got.new_packet = new_packet;
			got.pos_x = pos_x;
			got.pos_y = pos_y;
			got.pos_z = pos_z;
			got.vel_x = vel_x;
			got.vel_y = vel_y;
			got.vel_z = vel_z;
			sb.check_result(got);
		end
		if (pop_left == 0) begin
			pop_mode = $urandom_range(0, 3);
			pop_left = (pop_mode == 3) ? $urandom_range(2, 40) : $urandom_range(8, 60);
		end
		pop_left--;
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom);
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.",
				sb.expected_readouts.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.absorb_byte(b);
		sent_total++;
		phase_items++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic send_header();
		send_byte(sb.first_sync);
		send_byte(sb.second_sync);
		send_byte(sb.frame_id);
	endtask

	task automatic send_packet();
		send_header();
		for (int k = 0; k < sipd_pkg::WORD_COUNT; k++)
			for (int j = 0; j < 4; j++)
				send_byte(frame_words[k][8*j +: 8]);
	endtask

	function automatic logic [7:0] other_than(logic [7:0] v);
		logic [7:0] b;
		b = 8'($urandom);
		return (b == v) ? ~v : b;
	endfunction

	function automatic logic [sipd_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_chunk();
		int kind;
		int n;
		kind = $urandom_range(0, 19);
		if (kind < 13) begin
			foreach (frame_words[k]) frame_words[k] = pick_word();
			send_packet();
		end else if (kind < 15) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom));
		end else if (kind < 17) begin
			send_byte(sb.first_sync);
			send_byte(other_than(sb.second_sync));
		end else if (kind < 19) begin
			send_byte(sb.first_sync);
			send_byte(sb.second_sync);
			send_byte(other_than(sb.frame_id));
		end else begin
			send_header();
			n = $urandom_range(1, sipd_pkg::PAYLOAD_BYTES - 1);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	task automatic cfg_write(input logic [sipd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic program_regs(input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] id);
		cfg_write(sipd_pkg::CFG_SYNC_FIRST, s1);
		cfg_write(sipd_pkg::CFG_SYNC_SECOND, s2);
		cfg_write(sipd_pkg::CFG_MESSAGE_ID, id);
		cfg_write(CFG_UNUSED_IDX, 8'($urandom));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.expected_readouts.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	initial begin
		logic [7:0] set_first[6];
		logic [7:0] set_second[6];
		logic [7:0] set_id[6];
		set_first  = '{8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'h1A};
		set_second = '{8'hFF, 8'h00, 8'h55, 8'hFF, 8'h00, 8'h1B};
		set_id     = '{8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'h2C};
		set_first[4]  = 8'($urandom);
		set_second[4] = 8'($urandom);
		set_id[4]     = 8'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678};
		send_packet();
		send_byte(sb.first_sync);
		send_byte(sb.first_sync);
		send_byte(sb.second_sync);
		send_byte(sb.first_sync);
		send_byte(sb.second_sync);
		send_byte(other_than(sb.frame_id));
		send_byte(8'h00);
		send_byte(8'hFF);

		for (int p = 0; p < 6; p++) begin
			settle();
			program_regs(set_first[p], set_second[p], set_id[p]);
			phase_items = 0;
			while (phase_items < PHASE_BYTES) random_chunk();
		end
		settle();

		$display("Run covered %0d bytes, %0d complete packets, %0d register writes, %0d settings.",
			sent_total, sb.packets, cfg_writes, settings);
		$display("Checked %0d results, %0d mismatches, %0d left pending.",
			sb.checked, sb.failures, sb.expected_readouts.size());
		if (sb.failures == 0 && sb.expected_readouts.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== sync_id_packet_deframer_unit.f =====
src/sipd_pkg.sv
src/sipd_fifo.sv
src/sipd_front.sv
src/sipd_back.sv
src/sync_id_packet_deframer_unit.sv
dv/tb_sync_id_packet_deframer_unit.sv
